// ----- rtl/dfv_pkg.sv -----
// Shared types and constants for the decision forest vote classifier.
// No dependencies; used by dfv_walk and decision_forest_vote_classifier_unit.

package dfv_pkg;

	localparam int MAX_TREES      = 8;
	localparam int NODES_PER_TREE = 256;
	localparam int FEATURE_COUNT  = 1024;
	localparam int MAX_DEPTH      = 128;

	// Derived widths
	localparam int TREE_W  = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
	localparam int TCNT_W  = $clog2(MAX_TREES + 1);
	localparam int SLOT_W  = $clog2(NODES_PER_TREE);
	localparam int NADDR_W = $clog2(MAX_TREES * NODES_PER_TREE);
	localparam int FADDR_W = $clog2(FEATURE_COUNT);
	localparam int STEP_W  = $clog2(MAX_DEPTH + 1);

	// Fixed field widths
	localparam int FVAL_W  = 16;
	localparam int CHILD_W = 8;
	localparam int FIDX_W  = 10;
	localparam int VOTE_W  = 4;
	localparam int CFG_IDX_W = 1;

	// Node kinds
	localparam logic [1:0] KIND_SPLIT = 2'd0;
	localparam logic [1:0] KIND_POS   = 2'd1;
	localparam logic [1:0] KIND_NEG   = 2'd2;

	// Verdict codes
	localparam logic [1:0] VERDICT_POS = 2'd0;
	localparam logic [1:0] VERDICT_NEG = 2'd1;
	localparam logic [1:0] VERDICT_TIE = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TREES_IN_USE    = 1'd1;

	localparam logic [VOTE_W-1:0] TREES_RESET = 4'd5;

	typedef struct packed {
		logic [1:0]         kind;
		logic [FIDX_W-1:0]  feature;
		logic [CHILD_W-1:0] left;
		logic [CHILD_W-1:0] right;
	} node_entry_t;

	localparam int NODE_ENTRY_W = $bits(node_entry_t);

	typedef struct packed {
		logic               re;
		logic [NADDR_W-1:0] addr;
	} node_rd_t;

	typedef struct packed {
		logic               re;
		logic [FADDR_W-1:0] addr;
	} feat_rd_t;

	typedef struct packed {
		logic              valid;
		logic [VOTE_W-1:0] pos;
		logic [VOTE_W-1:0] neg;
		logic [1:0]        verdict;
		logic              err;
	} walk_res_t;

	typedef enum logic [1:0] {
		WS_IDLE,
		WS_NODE,
		WS_FEAT,
		WS_DONE
	} walk_state_t;

	function automatic logic [NADDR_W-1:0] node_addr(input logic [TREE_W-1:0] tree,
			input logic [SLOT_W-1:0] slot);
		return NADDR_W'(int'(tree) * NODES_PER_TREE + int'(slot));
	endfunction

endpackage

// ----- rtl/dfv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module dfv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/dfv_walk.sv -----
// Tree walk sequencer: steps each tree in use through the node and feature RAMs
// and tallies the votes. Depends on dfv_pkg.

module dfv_walk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dfv_pkg::FVAL_W-1:0]    threshold,
	input  logic [dfv_pkg::VOTE_W-1:0]    trees_in_use,
	input  dfv_pkg::node_entry_t          node_rdata,
	input  logic [dfv_pkg::FVAL_W-1:0]    feat_rdata,
	input  logic                          res_take,
	output logic                          busy,
	output dfv_pkg::node_rd_t             node_rd,
	output dfv_pkg::feat_rd_t             feat_rd,
	output dfv_pkg::walk_res_t            res
);

	dfv_pkg::walk_state_t state_q, state_nx;

	logic [dfv_pkg::TCNT_W-1:0] tree_q;
	logic [dfv_pkg::STEP_W-1:0] steps_q;
	logic [dfv_pkg::TCNT_W-1:0] pos_q, neg_q;
	logic                       err_q;
	logic                       feat_zero_q;

	logic [dfv_pkg::TCNT_W-1:0] n_trees;
	logic [dfv_pkg::TCNT_W-1:0] tree_nx;
	logic                       tree_last;
	logic                       is_split;
	logic                       depth_hit;
	logic [dfv_pkg::FVAL_W-1:0] feat_val;
	logic [dfv_pkg::CHILD_W-1:0] child;
	logic                       child_bad;
	logic                       feat_oob;

	always_comb begin
		n_trees = (32'(trees_in_use) > 32'(dfv_pkg::MAX_TREES))
			? dfv_pkg::TCNT_W'(dfv_pkg::MAX_TREES) : dfv_pkg::TCNT_W'(trees_in_use);
		tree_nx   = tree_q + dfv_pkg::TCNT_W'(1);
		tree_last = (tree_nx == n_trees);
		is_split  = (node_rdata.kind == dfv_pkg::KIND_SPLIT);
		depth_hit = (32'(steps_q) >= 32'(dfv_pkg::MAX_DEPTH));
		feat_oob  = (32'(node_rdata.feature) >= 32'(dfv_pkg::FEATURE_COUNT));
		feat_val  = feat_zero_q ? '0 : feat_rdata;
		child     = (feat_val > threshold) ? node_rdata.right : node_rdata.left;
		child_bad = (32'(child) >= 32'(dfv_pkg::NODES_PER_TREE));
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			dfv_pkg::WS_IDLE: begin
				if (start) begin
					state_nx = (n_trees == '0) ? dfv_pkg::WS_DONE : dfv_pkg::WS_NODE;
				end
			end
			dfv_pkg::WS_NODE: begin
				if (!is_split || depth_hit) begin
					state_nx = tree_last ? dfv_pkg::WS_DONE : dfv_pkg::WS_NODE;
				end else begin
					state_nx = dfv_pkg::WS_FEAT;
				end
			end
			dfv_pkg::WS_FEAT: begin
				if (child_bad && tree_last) begin
					state_nx = dfv_pkg::WS_DONE;
				end else begin
					state_nx = dfv_pkg::WS_NODE;
				end
			end
			dfv_pkg::WS_DONE: begin
				if (res_take) begin
					state_nx = dfv_pkg::WS_IDLE;
				end
			end
			default: state_nx = dfv_pkg::WS_IDLE;
		endcase
	end

	// outputs: RAM read requests and result
	always_comb begin
		node_rd = '0;
		feat_rd = '0;
		unique case (state_q)
			dfv_pkg::WS_IDLE: begin
				node_rd.re   = start;
				node_rd.addr = dfv_pkg::node_addr('0, '0);
			end
			dfv_pkg::WS_NODE: begin
				if (!is_split || depth_hit) begin
					node_rd.re   = !tree_last;
					node_rd.addr = dfv_pkg::node_addr(dfv_pkg::TREE_W'(tree_nx), '0);
				end else begin
					feat_rd.re   = !feat_oob;
					feat_rd.addr = dfv_pkg::FADDR_W'(node_rdata.feature);
				end
			end
			dfv_pkg::WS_FEAT: begin
				if (child_bad) begin
					node_rd.re   = !tree_last;
					node_rd.addr = dfv_pkg::node_addr(dfv_pkg::TREE_W'(tree_nx), '0);
				end else begin
					node_rd.re   = 1'b1;
					node_rd.addr = dfv_pkg::node_addr(dfv_pkg::TREE_W'(tree_q),
						dfv_pkg::SLOT_W'(child));
				end
			end
			dfv_pkg::WS_DONE: begin
			end
			default: begin
			end
		endcase

		busy        = (state_q != dfv_pkg::WS_IDLE);
		res.valid   = (state_q == dfv_pkg::WS_DONE);
		res.pos     = dfv_pkg::VOTE_W'(pos_q);
		res.neg     = dfv_pkg::VOTE_W'(neg_q);
		res.err     = err_q;
		if (pos_q > neg_q) begin
			res.verdict = dfv_pkg::VERDICT_POS;
		end else if (neg_q > pos_q) begin
			res.verdict = dfv_pkg::VERDICT_NEG;
		end else begin
			res.verdict = dfv_pkg::VERDICT_TIE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dfv_pkg::WS_IDLE;
			tree_q      <= '0;
			steps_q     <= '0;
			pos_q       <= '0;
			neg_q       <= '0;
			err_q       <= 1'b0;
			feat_zero_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			unique case (state_q)
				dfv_pkg::WS_IDLE: begin
					if (start) begin
						tree_q  <= '0;
						steps_q <= '0;
						pos_q   <= '0;
						neg_q   <= '0;
						err_q   <= 1'b0;
					end
				end
				dfv_pkg::WS_NODE: begin
					if (!is_split) begin
						// kind three counts as a negative leaf
						if (node_rdata.kind == dfv_pkg::KIND_POS) begin
							pos_q <= pos_q + dfv_pkg::TCNT_W'(1);
						end else begin
							neg_q <= neg_q + dfv_pkg::TCNT_W'(1);
						end
						tree_q  <= tree_nx;
						steps_q <= '0;
					end else if (depth_hit) begin
						err_q   <= 1'b1;
						tree_q  <= tree_nx;
						steps_q <= '0;
					end else begin
						feat_zero_q <= feat_oob;
					end
				end
				dfv_pkg::WS_FEAT: begin
					if (child_bad) begin
						err_q   <= 1'b1;
						tree_q  <= tree_nx;
						steps_q <= '0;
					end else begin
						steps_q <= steps_q + dfv_pkg::STEP_W'(1);
					end
				end
				dfv_pkg::WS_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/decision_forest_vote_classifier_unit.sv -----
// Top level of the decision forest vote classifier: config registers, node and
// feature RAMs, walk sequencer and result register. Depends on dfv_pkg, dfv_ram, dfv_walk.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------------------
//   in      | in        | in_valid / in_stall      | mode .. last_feature
//   out     | out       | out_valid / out_stall    | positive_votes .. walk_error
//   cfg     | in        | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// Node writes and feature loads take one beat per cycle, back to back, outside walks.
// A feature beat with last_feature set starts the walk; the input stalls until it ends.
// The walk takes the trees in use in turn: a node RAM read per node reached and, for
// each split passed, a feature RAM read in between; a leaf or an abort ends a tree.
// Reset clears control state, zeroes threshold, sets 5 trees in use; RAMs start undefined.
// A result held in the output register does not block node writes or feature loads;
// a second result then waits in the walker and keeps the input stalled.

module decision_forest_vote_classifier_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  mode,
	input  logic [2:0]                            tree_index,
	input  logic [7:0]                            node_index,
	input  logic [1:0]                            node_kind,
	input  logic [dfv_pkg::FIDX_W-1:0]            split_feature,
	input  logic [dfv_pkg::CHILD_W-1:0]           left_child,
	input  logic [dfv_pkg::CHILD_W-1:0]           right_child,
	input  logic [dfv_pkg::FIDX_W-1:0]            feature_index,
	input  logic [dfv_pkg::FVAL_W-1:0]            feature_value,
	input  logic                                  last_feature,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [dfv_pkg::VOTE_W-1:0]            positive_votes,
	output logic [dfv_pkg::VOTE_W-1:0]            negative_votes,
	output logic [1:0]                            verdict,
	output logic                                  walk_error,
	// configuration
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dfv_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dfv_pkg::FVAL_W-1:0]            cfg_data
);

	logic [dfv_pkg::FVAL_W-1:0] threshold_q;
	logic [dfv_pkg::VOTE_W-1:0] trees_q;

	logic                       in_beat;
	logic                       start;
	logic                       node_we;
	logic [dfv_pkg::NADDR_W-1:0] node_waddr;
	dfv_pkg::node_entry_t       node_wdata;
	dfv_pkg::node_entry_t       node_rdata;
	logic                       feat_we;
	logic [dfv_pkg::FVAL_W-1:0] feat_rdata;

	dfv_pkg::node_rd_t          node_rd;
	dfv_pkg::feat_rd_t          feat_rd;
	dfv_pkg::walk_res_t         res;
	logic                       walk_busy;
	logic                       res_take;

	logic                       out_valid_q;
	logic [dfv_pkg::VOTE_W-1:0] pos_q, neg_q;
	logic [1:0]                 verdict_q;
	logic                       err_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			trees_q     <= dfv_pkg::TREES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dfv_pkg::REG_SPLIT_THRESHOLD: threshold_q <= cfg_data;
				dfv_pkg::REG_TREES_IN_USE:    trees_q     <= cfg_data[dfv_pkg::VOTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = walk_busy;
	assign in_beat  = in_valid && !in_stall;
	assign start    = in_beat && mode && last_feature;

	always_comb begin
		node_we = in_beat && !mode
			&& (32'(tree_index) < 32'(dfv_pkg::MAX_TREES))
			&& (32'(node_index) < 32'(dfv_pkg::NODES_PER_TREE));
		node_waddr = dfv_pkg::node_addr(dfv_pkg::TREE_W'(tree_index),
			dfv_pkg::SLOT_W'(node_index));
		node_wdata.kind    = node_kind;
		node_wdata.feature = split_feature;
		node_wdata.left    = left_child;
		node_wdata.right   = right_child;
		feat_we = in_beat && mode
			&& (32'(feature_index) < 32'(dfv_pkg::FEATURE_COUNT));
	end

	dfv_ram #(
		.WIDTH(dfv_pkg::NODE_ENTRY_W),
		.DEPTH(dfv_pkg::MAX_TREES * dfv_pkg::NODES_PER_TREE)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.re    (node_rd.re),
		.raddr (node_rd.addr),
		.rdata (node_rdata)
	);

	dfv_ram #(
		.WIDTH(dfv_pkg::FVAL_W),
		.DEPTH(dfv_pkg::FEATURE_COUNT)
	) u_feat_ram (
		.clk   (clk),
		.we    (feat_we),
		.waddr (dfv_pkg::FADDR_W'(feature_index)),
		.wdata (feature_value),
		.re    (feat_rd.re),
		.raddr (feat_rd.addr),
		.rdata (feat_rdata)
	);

	dfv_walk u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.threshold    (threshold_q),
		.trees_in_use (trees_q),
		.node_rdata   (node_rdata),
		.feat_rdata   (feat_rdata),
		.res_take     (res_take),
		.busy         (walk_busy),
		.node_rd      (node_rd),
		.feat_rd      (feat_rd),
		.res          (res)
	);

	// result register frees the walker as soon as the slot is empty or draining
	assign res_take = res.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			pos_q     <= res.pos;
			neg_q     <= res.neg;
			verdict_q <= res.verdict;
			err_q     <= res.err;
		end
	end

	assign out_valid      = out_valid_q;
	assign positive_votes = pos_q;
	assign negative_votes = neg_q;
	assign verdict        = verdict_q;
	assign walk_error     = err_q;

	// node table is only written between walks
	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		node_we |-> !walk_busy)
		else $error("node write during walk");

	a_no_rd_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(node_we && node_rd.re))
		else $error("node RAM read and write in same cycle");

	a_verdict_tie: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((verdict == dfv_pkg::VERDICT_TIE) == (positive_votes == negative_votes)))
		else $error("verdict disagrees with vote counts");

	a_vote_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(positive_votes) + 32'(negative_votes) <= 32'(dfv_pkg::MAX_TREES)))
		else $error("more votes than trees");

endmodule

// ----- tb/sv/dfv_vote_checker.sv -----
// Scoreboard for the decision forest vote classifier: mirrors the node table,
// the feature store and both registers, predicts each vote and checks the results.
// Depends on dfv_pkg; also holds dfv_tb_pkg, the codes shared with the testbench top.

package dfv_tb_pkg;

	localparam logic       MODE_NODE    = 1'b0;
	localparam logic       MODE_FEATURE = 1'b1;
	// Unassigned kind code; a walk treats it as a negative leaf
	localparam logic [1:0] KIND_SPARE   = 2'd3;

endpackage

module dfv_vote_checker
	import dfv_pkg::*;
	import dfv_tb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 mode,
	input  logic [2:0]           tree_index,
	input  logic [7:0]           node_index,
	input  logic [1:0]           node_kind,
	input  logic [FIDX_W-1:0]    split_feature,
	input  logic [CHILD_W-1:0]   left_child,
	input  logic [CHILD_W-1:0]   right_child,
	input  logic [FIDX_W-1:0]    feature_index,
	input  logic [FVAL_W-1:0]    feature_value,
	input  logic                 last_feature,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [VOTE_W-1:0]    positive_votes,
	input  logic [VOTE_W-1:0]    negative_votes,
	input  logic [1:0]           verdict,
	input  logic                 walk_error,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FVAL_W-1:0]    cfg_data,
	output int                   fail_count,
	output int                   pending
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [VOTE_W-1:0] pos;
		logic [VOTE_W-1:0] neg;
		logic [1:0]        verdict;
		logic              err;
	} vote_tally_t;

	typedef enum logic [1:0] {TREE_ABORTED, TREE_POS, TREE_NEG} tree_vote_e;

	node_entry_t       forest [MAX_TREES][NODES_PER_TREE];
	logic [FVAL_W-1:0] features [FEATURE_COUNT];
	logic [FVAL_W-1:0] threshold;
	logic [3:0]        trees_used;
	vote_tally_t       tally_q [$];

	task automatic report(input string what);
		fail_count++;
		$display("%0t ns  mismatch: %s", $realtime, what);
	endtask

	task automatic compare_field(input string name, input logic [VOTE_W-1:0] got,
			input logic [VOTE_W-1:0] want);
		if (got !== want)
			report($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	function automatic tree_vote_e walk_tree(input int tree);
		int                slot;
		int                passed;
		node_entry_t       ent;
		logic [FVAL_W-1:0] fval;
		logic [7:0]        next;
		slot   = 0;
		passed = 0;
		while (1) begin
			ent = forest[tree][slot];
			if (ent.kind == KIND_POS)
				return TREE_POS;
			if (ent.kind != KIND_SPLIT)
				return TREE_NEG;
			// only MAX_DEPTH splits may be passed before landing on a leaf
			if (passed >= MAX_DEPTH)
				return TREE_ABORTED;
			fval = (int'(ent.feature) < FEATURE_COUNT) ? features[ent.feature] : '0;
			next = (fval > threshold) ? ent.right : ent.left;
			if (int'(next) >= NODES_PER_TREE)
				return TREE_ABORTED;
			slot = next;
			passed++;
		end
	endfunction

	function automatic vote_tally_t count_votes();
		vote_tally_t tally;
		int          n;
		int          i;
		tally = '0;
		n = (trees_used > MAX_TREES) ? MAX_TREES : int'(trees_used);
		for (i = 0; i < n; i++) begin
			case (walk_tree(i))
				TREE_POS: tally.pos = tally.pos + 1'b1;
				TREE_NEG: tally.neg = tally.neg + 1'b1;
				default:  tally.err = 1'b1;
			endcase
		end
		if (tally.pos > tally.neg)
			tally.verdict = VERDICT_POS;
		else if (tally.neg > tally.pos)
			tally.verdict = VERDICT_NEG;
		else
			tally.verdict = VERDICT_TIE;
		return tally;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		vote_tally_t want;
		if (!arst_n) begin
			threshold  = '0;
			trees_used = TREES_RESET;
			tally_q.delete();
			pending    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SPLIT_THRESHOLD)
					threshold = cfg_data;
				else if (cfg_index == REG_TREES_IN_USE)
					trees_used = cfg_data[3:0];
			end
			if (in_valid && !in_stall) begin
				if (mode == MODE_NODE) begin
					// last_feature means nothing on a node write
					forest[tree_index][node_index] =
						{node_kind, split_feature, left_child, right_child};
				end else begin
					features[feature_index] = feature_value;
					if (last_feature)
						tally_q.insert(tally_q.size(), count_votes());
				end
			end
			if (out_valid && !out_stall) begin
				if (tally_q.size() == 0) begin
					report($sformatf("unexpected result beat: pos %0d neg %0d",
						positive_votes, negative_votes));
				end else begin
					want = tally_q.pop_front();
					compare_field("positive_votes", positive_votes, want.pos);
					compare_field("negative_votes", negative_votes, want.neg);
					compare_field("verdict", verdict, want.verdict);
					compare_field("walk_error", walk_error, want.err);
				end
			end
			pending = tally_q.size();
		end
	end

endmodule

// ----- tb/sv/tb_decision_forest_vote_classifier_unit.sv -----
// Testbench top for decision_forest_vote_classifier_unit: builds forests and samples,
// sweeps both registers, idles and stalls at random and gives the verdict.
// Depends on dfv_pkg, dfv_tb_pkg and dfv_vote_checker (tb/sv/dfv_vote_checker.sv).

module tb_decision_forest_vote_classifier_unit;

	timeunit 1ns;
	timeprecision 1ps;

	import dfv_pkg::*;
	import dfv_tb_pkg::*;

	localparam int IDLE_PCT       = 38;
	localparam int RX_HOLD_CYCLES = 5000;
	localparam int QUIET_LIMIT    = 50000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int SETTLE_CYCLES  = 20;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 32;
	localparam int FILL_VOTES     = 3;

	typedef struct packed {
		logic               mode;
		logic [2:0]         tree;
		logic [7:0]         slot;
		logic [1:0]         kind;
		logic [FIDX_W-1:0]  feat;
		logic [CHILD_W-1:0] left;
		logic [CHILD_W-1:0] right;
		logic [FIDX_W-1:0]  fidx;
		logic [FVAL_W-1:0]  fval;
		logic               last;
	} forest_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 mode;
	logic [2:0]           tree_index;
	logic [7:0]           node_index;
	logic [1:0]           node_kind;
	logic [FIDX_W-1:0]    split_feature;
	logic [CHILD_W-1:0]   left_child;
	logic [CHILD_W-1:0]   right_child;
	logic [FIDX_W-1:0]    feature_index;
	logic [FVAL_W-1:0]    feature_value;
	logic                 last_feature;
	logic                 out_valid;
	logic                 out_stall;
	logic [VOTE_W-1:0]    positive_votes;
	logic [VOTE_W-1:0]    negative_votes;
	logic [1:0]           verdict;
	logic                 walk_error;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FVAL_W-1:0]    cfg_data;
	int                   fail_count;
	int                   pending;

	// Walks may only touch written entries, so every split points at written
	// slots of its own tree and tests a written feature.
	int                slot_list [MAX_TREES][$];
	bit                slot_known [MAX_TREES][NODES_PER_TREE];
	int                feat_list [$];
	bit                feat_known [FEATURE_COUNT];
	logic [FVAL_W-1:0] cur_threshold = '0;
	bit                tx_eager = 1'b0;
	bit                rx_eager = 1'b0;
	int                hold_token = 0;
	int                quiet_cycles = 0;

	always #5ns clk = ~clk;

	decision_forest_vote_classifier_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .tree_index(tree_index), .node_index(node_index),
		.node_kind(node_kind), .split_feature(split_feature),
		.left_child(left_child), .right_child(right_child),
		.feature_index(feature_index), .feature_value(feature_value),
		.last_feature(last_feature),
		.out_valid(out_valid), .out_stall(out_stall),
		.positive_votes(positive_votes), .negative_votes(negative_votes),
		.verdict(verdict), .walk_error(walk_error),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	dfv_vote_checker vote_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .tree_index(tree_index), .node_index(node_index),
		.node_kind(node_kind), .split_feature(split_feature),
		.left_child(left_child), .right_child(right_child),
		.feature_index(feature_index), .feature_value(feature_value),
		.last_feature(last_feature),
		.out_valid(out_valid), .out_stall(out_stall),
		.positive_votes(positive_votes), .negative_votes(negative_votes),
		.verdict(verdict), .walk_error(walk_error),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result receiver: random stalls, eager stretches, and one long hold-off on request
	initial begin : receiver
		int hold_seen;
		hold_seen = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				out_stall <= 1'b1;
				repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
			end else if (rx_eager) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	task automatic send_beat(input forest_beat_t b);
		if (!tx_eager)
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid      <= 1'b1;
		mode          <= b.mode;
		tree_index    <= b.tree;
		node_index    <= b.slot;
		node_kind     <= b.kind;
		split_feature <= b.feat;
		left_child    <= b.left;
		right_child   <= b.right;
		feature_index <= b.fidx;
		feature_value <= b.fval;
		last_feature  <= b.last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic put_node(input int tree, input int slot, input logic [1:0] kind,
			input int feat, input int left, input int right);
		forest_beat_t b;
		// fields a node write ignores (last_feature too) stay random
		b       = forest_beat_t'({$urandom(), $urandom(), $urandom()});
		b.mode  = MODE_NODE;
		b.tree  = 3'(tree);
		b.slot  = 8'(slot);
		b.kind  = kind;
		b.feat  = FIDX_W'(feat);
		b.left  = CHILD_W'(left);
		b.right = CHILD_W'(right);
		send_beat(b);
		if (!slot_known[tree][slot]) begin
			slot_known[tree][slot] = 1'b1;
			slot_list[tree].insert(slot_list[tree].size(), slot);
		end
	endtask

	task automatic put_feature(input int fidx, input logic [FVAL_W-1:0] fval, input logic last);
		forest_beat_t b;
		b      = forest_beat_t'({$urandom(), $urandom(), $urandom()});
		b.mode = MODE_FEATURE;
		b.fidx = FIDX_W'(fidx);
		b.fval = fval;
		b.last = last;
		send_beat(b);
		if (!feat_known[fidx]) begin
			feat_known[fidx] = 1'b1;
			feat_list.insert(feat_list.size(), fidx);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Registers change only with the block idle; junk above bit 3 of the tree count
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FVAL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [FVAL_W-1:0] thr, input logic [3:0] trees);
		wait_drained();
		write_reg(REG_SPLIT_THRESHOLD, thr);
		write_reg(REG_TREES_IN_USE, {12'($urandom()), trees});
		cfg_valid <= 1'b0;
		cur_threshold = thr;
	endtask

	function automatic int pick_slot(input int tree);
		return slot_list[tree][$urandom_range(slot_list[tree].size() - 1)];
	endfunction

	function automatic int pick_feature();
		return feat_list[$urandom_range(feat_list.size() - 1)];
	endfunction

	function automatic logic [FVAL_W-1:0] feature_sample();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			// straddle the threshold, wrapping at the ends
			2:       return cur_threshold + FVAL_W'($urandom_range(2)) - 1'b1;
			default: return FVAL_W'($urandom());
		endcase
	endfunction

	task automatic grow_forest();
		int tree;
		int slot;
		int r;
		tree = $urandom_range(MAX_TREES - 1);
		slot = $urandom_range(1) ? $urandom_range(15) : $urandom_range(NODES_PER_TREE - 1);
		r    = $urandom_range(99);
		if (r < 45)
			put_node(tree, slot, KIND_SPLIT, pick_feature(), pick_slot(tree), pick_slot(tree));
		else
			put_node(tree, slot, (r < 70) ? KIND_POS : (r < 92) ? KIND_NEG : KIND_SPARE,
				$urandom_range(1023), $urandom_range(255), $urandom_range(255));
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			put_feature($urandom_range(FEATURE_COUNT - 1), feature_sample(), 1'b0);
		else if (r < 56)
			put_feature($urandom_range(FEATURE_COUNT - 1), feature_sample(), 1'b1);
		else
			grow_forest();
	endtask

	// Tree 7 becomes a chain of exactly MAX_DEPTH splits ending on a leaf,
	// then one split longer, which must abort the walk.
	task automatic deep_chain();
		int s;
		put_node(7, MAX_DEPTH, KIND_POS, 0, 0, 0);
		for (s = MAX_DEPTH - 1; s >= 0; s--)
			put_node(7, s, KIND_SPLIT, pick_feature(), s + 1, s + 1);
		put_feature($urandom_range(FEATURE_COUNT - 1), feature_sample(), 1'b1);
		put_node(7, MAX_DEPTH + 1, KIND_NEG, 0, 0, 0);
		put_node(7, MAX_DEPTH, KIND_SPLIT, pick_feature(), MAX_DEPTH + 1, MAX_DEPTH + 1);
		put_feature($urandom_range(FEATURE_COUNT - 1), feature_sample(), 1'b1);
	endtask

	initial begin : stimulus
		int t;
		int ph;
		int i;
		int thr;
		int trees;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		mode          <= MODE_NODE;
		tree_index    <= '0;
		node_index    <= '0;
		node_kind     <= KIND_SPLIT;
		split_feature <= '0;
		left_child    <= '0;
		right_child   <= '0;
		feature_index <= '0;
		feature_value <= '0;
		last_feature  <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_SPLIT_THRESHOLD;
		cfg_data      <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, every leaf kind, loops, register corners
		put_feature(FEATURE_COUNT - 1, '1, 1'b0);
		put_feature(0, '0, 1'b0);
		for (t = 0; t < MAX_TREES; t++)
			put_node(t, 0, (t % 3 == 0) ? KIND_POS : (t % 3 == 1) ? KIND_NEG : KIND_SPARE,
				t * 146, 255, 0);
		// reset setting: five trees vote, 2 positive against 3 negative
		put_feature(512, 16'd1, 1'b1);
		put_node(0, 255, KIND_POS, 0, 0, 0);
		put_node(0, 1, KIND_NEG, 0, 0, 0);
		put_node(0, 0, KIND_SPLIT, FEATURE_COUNT - 1, 1, 255);
		// root that loops on itself: depth limit
		put_node(1, 0, KIND_SPLIT, 0, 0, 0);
		put_feature(1, 16'd7, 1'b1);
		// top threshold: nothing goes right
		configure('1, 4'd8);
		put_feature(FEATURE_COUNT - 1, '1, 1'b1);
		configure('0, 4'd0);
		put_feature(2, 16'd3, 1'b1);
		// tree count beyond the table acts as all trees
		configure('0, 4'd15);
		put_feature(0, '0, 1'b1);

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       thr = 0;
				1, 3:    thr = 16'hFFFF;
				default: thr = $urandom_range(16'hFFFF);
			endcase
			case (ph)
				0:       trees = 1;
				1, 4, 5: trees = MAX_TREES;
				3:       trees = 0;
				6:       trees = $urandom_range(15, MAX_TREES + 1);
				default: trees = $urandom_range(MAX_TREES - 1, 2);
			endcase
			configure(FVAL_W'(thr), 4'(trees));
			tx_eager = (ph == 2);
			rx_eager <= (ph == 2);
			if (ph == 4)
				hold_token <= hold_token + 1;
			if (ph == 5)
				deep_chain();
			for (i = 0; i < PHASE_ITEMS; i++) begin
				// sender waits out every outstanding vote mid-phase
				if (ph == 6 && i == PHASE_ITEMS / 2)
					wait_drained();
				// votes pile up behind the held receiver until the input stalls
				if (ph == 4 && i < FILL_VOTES)
					put_feature(pick_feature(), feature_sample(), 1'b1);
				else
					random_item();
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
